[rtl/tcw_pkg.sv]
// Package for the text console writer: payload structs, command struct,
// character codes and state encodings. No dependencies.
package tcw_pkg;

   localparam int COLUMNS_DEFAULT = 80;
   localparam int ROWS_DEFAULT    = 25;

   // Widest cell address over the whole parameter range (128 rows x 256 columns)
   localparam int CELL_ADDR_W_MAX = 15;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] TEXT_COLOR_RESET = 8'h07;

   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_RETURN  = 8'h0D;
   localparam logic [7:0] CH_SPACE   = 8'h20;

   localparam logic [1:0] MODE_WRITE = 2'd0;
   localparam logic [1:0] MODE_CLEAR = 2'd1;
   localparam logic [1:0] MODE_READ  = 2'd2;

   typedef struct packed {
      logic [1:0]  mode;
      logic [7:0]  char_code;
      logic [10:0] cell_index;
   } req_payload_type;

   typedef struct packed {
      logic [4:0]  cursor_row;
      logic [6:0]  cursor_col;
      logic [10:0] cursor_index;
      logic        scrolled;
      logic [15:0] cell_word;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      OP_PLAIN,
      OP_READ,
      OP_CLEAR
   } cmd_op_type;

   // One classified transaction handed from the front to the back
   typedef struct packed {
      cmd_op_type                  op;
      logic                        store;
      logic [CELL_ADDR_W_MAX-1:0]  addr;
      logic [15:0]                 data;
      logic [4:0]                  cursor_row;
      logic [6:0]                  cursor_col;
      logic [10:0]                 cursor_index;
      logic                        scrolled;
   } cmd_type;

   typedef enum logic [1:0] {
      BK_RUN,
      BK_COPY,
      BK_FILL
   } back_state_type;

endpackage

[rtl/tcw_front.sv]
// Front end: accepts transactions, owns cursor and colour register, and
// classifies each transaction into a command. Depends on tcw_pkg.
module tcw_front import tcw_pkg::*; #(
   parameter int ROWS    = ROWS_DEFAULT,
   parameter int COLUMNS = COLUMNS_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  req_payload_type req_item,
   input  logic            csr_wr_en,
   input  logic [7:0]      csr_wr_data,
   input  logic            queue_full,
   output logic            push,
   output cmd_type         push_cmd
);

   localparam int CELLS = ROWS * COLUMNS;
   localparam int AW    = $clog2(CELLS);
   localparam int RW    = $clog2(ROWS);
   localparam int CW    = $clog2(COLUMNS);

   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   logic [7:0]    color_ff;

   logic [RW:0]   row_step;
   logic [CW:0]   col_step;
   logic          store;
   logic          scrolled;
   cmd_op_type    op;
   logic [AW-1:0] cur_addr;
   logic [31:0]   new_index;

   assign busy = queue_full;
   assign push = start & ~queue_full;

   always_comb begin
      row_step = {1'b0, row_ff};
      col_step = {1'b0, col_ff};
      store    = 1'b0;
      scrolled = 1'b0;
      op       = OP_PLAIN;
      case (req_item.mode)
         MODE_WRITE: begin
            if (req_item.char_code == CH_NEWLINE) begin
               col_step = '0;
               row_step = row_step + (RW+1)'(1);
            end else if (req_item.char_code == CH_RETURN) begin
               col_step = '0;
            end else if (req_item.char_code == CH_TAB) begin
               col_step = (col_step + (CW+1)'(4)) & ~(CW+1)'(3);
            end else begin
               store    = 1'b1;
               col_step = col_step + (CW+1)'(1);
            end
            if (col_step >= (CW+1)'(COLUMNS)) begin
               col_step = '0;
               row_step = row_step + (RW+1)'(1);
            end
            if (row_step >= (RW+1)'(ROWS)) begin
               row_step = (RW+1)'(ROWS - 1);
               scrolled = 1'b1;
            end
         end
         MODE_CLEAR: begin
            op       = OP_CLEAR;
            row_step = '0;
            col_step = '0;
         end
         MODE_READ: begin
            // out-of-range reads report a zero word and touch nothing
            if (32'(req_item.cell_index) < CELLS) begin
               op = OP_READ;
            end
         end
         default: begin
         end
      endcase
      row_in = row_step[RW-1:0];
      col_in = col_step[CW-1:0];
   end

   assign cur_addr  = AW'(32'(row_ff) * COLUMNS + 32'(col_ff));
   assign new_index = 32'(row_in) * COLUMNS + 32'(col_in);

   always_comb begin
      push_cmd.op           = op;
      push_cmd.store        = store;
      push_cmd.addr         = (op == OP_READ) ? CELL_ADDR_W_MAX'(req_item.cell_index)
                                              : CELL_ADDR_W_MAX'(cur_addr);
      push_cmd.data         = {color_ff, req_item.char_code};
      push_cmd.cursor_row   = 5'(row_in);
      push_cmd.cursor_col   = 7'(col_in);
      push_cmd.cursor_index = new_index[10:0];
      push_cmd.scrolled     = scrolled;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff   <= '0;
         col_ff   <= '0;
         color_ff <= TEXT_COLOR_RESET;
      end else begin
         if (push) begin
            row_ff <= row_in;
            col_ff <= col_in;
         end
         if (csr_wr_en) begin
            color_ff <= csr_wr_data;
         end
      end
   end

endmodule

[rtl/tcw_queue.sv]
// Short command queue between front and back end.
// Depends on tcw_pkg for the command struct.
module tcw_queue import tcw_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output logic    full,
   output logic    head_valid,
   output cmd_type head_cmd
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   cmd_type         entry_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PW:0]     count_ff, count_in;

   assign full       = (count_ff == (PW+1)'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + (PW+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (PW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[rtl/tcw_back.sv]
// Back end: screen store, scroll and clear sweeps, and the result stage.
// Depends on tcw_pkg.
module tcw_back import tcw_pkg::*; #(
   parameter int ROWS    = ROWS_DEFAULT,
   parameter int COLUMNS = COLUMNS_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            cmd_valid,
   input  cmd_type         cmd,
   output logic            pop,
   output logic            rsp_strobe,
   output rsp_payload_type rsp_item
);

   localparam int CELLS = ROWS * COLUMNS;
   localparam int AW    = $clog2(CELLS);

   logic [15:0]    screen_mem [CELLS];
   logic [15:0]    rd_data_ff;

   back_state_type state_ff, state_in;
   logic [AW-1:0]  cnt_ff, cnt_in;
   cmd_type        cur_ff, cur_in;
   logic           pend_valid_ff, pend_valid_in;
   cmd_type        pend_ff, pend_in;
   logic           pend_read_ff, pend_read_in;

   logic           we;
   logic [AW-1:0]  wa;
   logic [15:0]    wd;
   logic [AW-1:0]  ra;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      cur_in        = cur_ff;
      pend_valid_in = 1'b0;
      pend_in       = pend_ff;
      pend_read_in  = 1'b0;
      pop           = 1'b0;
      we            = 1'b0;
      wa            = '0;
      wd            = '0;
      ra            = '0;
      case (state_ff)
         BK_RUN: begin
            if (cmd_valid) begin
               pop = 1'b1;
               ra  = cmd.addr[AW-1:0];
               if (cmd.store) begin
                  we = 1'b1;
                  wa = cmd.addr[AW-1:0];
                  wd = cmd.data;
               end
               if (cmd.op == OP_CLEAR) begin
                  state_in = BK_FILL;
                  cnt_in   = '0;
                  cur_in   = cmd;
               end else if (cmd.scrolled) begin
                  state_in = BK_COPY;
                  cnt_in   = '0;
                  cur_in   = cmd;
               end else begin
                  pend_valid_in = 1'b1;
                  pend_in       = cmd;
                  pend_read_in  = (cmd.op == OP_READ);
               end
            end
         end
         BK_COPY: begin
            // read one row ahead, write the word read last cycle one place back
            if (cnt_ff != AW'(CELLS - COLUMNS)) begin
               ra = cnt_ff + AW'(COLUMNS);
            end
            if (cnt_ff != '0) begin
               we = 1'b1;
               wa = cnt_ff - AW'(1);
               wd = rd_data_ff;
            end
            if (cnt_ff == AW'(CELLS - COLUMNS)) begin
               state_in = BK_FILL;
            end else begin
               cnt_in = cnt_ff + AW'(1);
            end
         end
         BK_FILL: begin
            we = 1'b1;
            wa = cnt_ff;
            wd = {cur_ff.data[15:8], CH_SPACE};
            if (cnt_ff == AW'(CELLS - 1)) begin
               state_in      = BK_RUN;
               pend_valid_in = 1'b1;
               pend_in       = cur_ff;
            end else begin
               cnt_in = cnt_ff + AW'(1);
            end
         end
         default: begin
            state_in = BK_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         screen_mem[wa] <= wd;
      end
      rd_data_ff <= screen_mem[ra];
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      pend_ff <= pend_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_RUN;
         cnt_ff        <= '0;
         pend_valid_ff <= 1'b0;
         pend_read_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         pend_valid_ff <= pend_valid_in;
         pend_read_ff  <= pend_read_in;
      end
   end

   assign rsp_strobe            = pend_valid_ff;
   assign rsp_item.cursor_row   = pend_ff.cursor_row;
   assign rsp_item.cursor_col   = pend_ff.cursor_col;
   assign rsp_item.cursor_index = pend_ff.cursor_index;
   assign rsp_item.scrolled     = pend_ff.scrolled;
   assign rsp_item.cell_word    = pend_read_ff ? rd_data_ff : 16'h0000;

endmodule

[rtl/text_console_writer.sv]
// Text console writer top level: front end, command queue and back end.
// Depends on tcw_pkg, tcw_front, tcw_queue and tcw_back.

// A transaction is taken on a clock edge with start high and busy low; its
// result leaves a back-end register on rsp_strobe/rsp_item for a single
// cycle, and results always come back in order. Characters, control codes
// and reads run at one per cycle while no sweep holds the back end: a write
// that scrolls or a clear holds it for a sweep, since the screen store moves
// one cell per cycle through its single write port; the front end keeps
// taking transactions until the two-entry command queue fills, then raises
// busy. The screen store is not cleared at reset: issue a clear before the
// first use. The result port cannot be stalled, so nothing waits on the
// receiver. The user must write text_color through csr_wr_en/csr_wr_data
// while idle; the block itself does not enforce this.
module text_console_writer import tcw_pkg::*; #(
   parameter int ROWS    = ROWS_DEFAULT,
   parameter int COLUMNS = COLUMNS_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  req_payload_type req_item,
   output logic            rsp_strobe,
   output rsp_payload_type rsp_item,
   input  logic            csr_wr_en,
   input  logic [7:0]      csr_wr_data
);

   logic    push;
   cmd_type push_cmd;
   logic    queue_full;
   logic    head_valid;
   cmd_type head_cmd;
   logic    pop;

   tcw_front #(
      .ROWS    (ROWS),
      .COLUMNS (COLUMNS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_item    (req_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .queue_full  (queue_full),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   tcw_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   tcw_back #(
      .ROWS    (ROWS),
      .COLUMNS (COLUMNS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (head_valid),
      .cmd        (head_cmd),
      .pop        (pop),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule

[rtl/tcw_checker.sv]
// Port-level checks for the text console writer, bound to the top level.
// Depends on tcw_pkg and text_console_writer.
module tcw_checker import tcw_pkg::*; #(
   parameter int ROWS    = ROWS_DEFAULT,
   parameter int COLUMNS = COLUMNS_DEFAULT
) (
   input logic            clock,
   input logic            reset,
   input logic            busy,
   input logic            rsp_strobe,
   input rsp_payload_type rsp_item
);

   // out of reset: nothing queued, no result pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !busy && !rsp_strobe)
      else $error("busy or result strobe after reset");

   // a scroll always leaves the cursor at the start of the bottom row
   a_scroll_home: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.scrolled |->
         rsp_item.cursor_col == 7'd0 && rsp_item.cursor_row == 5'(ROWS - 1))
      else $error("scroll did not leave cursor at bottom row start");

   // linear index agrees with row and column where those fields are not cut short
   a_index: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |->
         (COLUMNS > 128) || (ROWS > 32) ||
         (rsp_item.cursor_index ==
            11'(32'(rsp_item.cursor_row) * COLUMNS + 32'(rsp_item.cursor_col))))
      else $error("cursor index does not match row and column");

endmodule

bind text_console_writer tcw_checker #(
   .ROWS    (ROWS),
   .COLUMNS (COLUMNS)
) u_tcw_checker (
   .clock      (clock),
   .reset      (reset),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_item   (rsp_item)
);
